// File: hdl/ctfe_pkg.sv
// ----------------------------------------------------------------------------
// ctfe_pkg
// shared types, field codes and the month length table for the
// calendar time field editor
// ----------------------------------------------------------------------------
package ctfe_pkg;

    localparam logic       REQ_LOAD   = 1'b0;
    localparam logic       REQ_ADJUST = 1'b1;

    localparam logic [2:0] FLD_HOUR   = 3'd0;
    localparam logic [2:0] FLD_MINUTE = 3'd1;
    localparam logic [2:0] FLD_YEAR   = 3'd2;
    localparam logic [2:0] FLD_MONTH  = 3'd3;
    localparam logic [2:0] FLD_DAY    = 3'd4;

    localparam logic [11:0] YEAR_MIN = 12'd2000;
    localparam logic [11:0] YEAR_MAX = 12'd2099;
    localparam logic [5:0]  HOUR_SPAN   = 6'd24;
    localparam logic [5:0]  MINUTE_SPAN = 6'd60;
    localparam logic [5:0]  MONTH_SPAN  = 6'd12;

    localparam int WRAP_W = 10;

    typedef struct packed {
        logic                     start;
        logic signed [WRAP_W-1:0] value;
        logic        [4:0]        lo;
        logic        [5:0]        span;
    } t_wrap_req;

    typedef struct packed {
        logic       done;
        logic [5:0] result;
    } t_wrap_rsp;

    function automatic logic [4:0] days_in(input logic [11:0] year, input logic [3:0] month);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: hdl/calendar_time_field_editor_unit.sv
// ----------------------------------------------------------------------------
// calendar_time_field_editor_unit
// date and time register set with load-and-clamp and per-field adjust
// ----------------------------------------------------------------------------
// One item is taken at a time. A load beat clamps each loaded field into
// its legal range, a zero step or an unused field select passes straight to
// the result, and a year step wraps within 2000..2099 and then clamps the day.
// Hour, minute, month and day steps go through the shared wrap unit, which
// adds or subtracts one span per cycle until the sum lies in the legal range;
// a month step is followed by a day clamp.
// The result sits in an output register, so the next beat is taken while it
// waits.
module calendar_time_field_editor_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [2:0]        i_field_sel,
    input  logic signed [7:0] i_delta,
    input  logic [15:0]       i_load_year,
    input  logic [7:0]        i_load_month,
    input  logic [7:0]        i_load_day,
    input  logic [7:0]        i_load_hour,
    input  logic [7:0]        i_load_minute,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [11:0]       o_cur_year,
    output logic [3:0]        o_cur_month,
    output logic [4:0]        o_cur_day,
    output logic [4:0]        o_cur_hour,
    output logic [5:0]        o_cur_minute
);
    import ctfe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_YEAR  = 7'b0000100,
        S_START = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_CLAMP = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state            r_state;
    t_state            n_state;

    logic [11:0]       r_year;
    logic [3:0]        r_month;
    logic [4:0]        r_day;
    logic [4:0]        r_hour;
    logic [5:0]        r_minute;
    logic [11:0]       n_year;
    logic [3:0]        n_month;
    logic [4:0]        n_day;
    logic [4:0]        n_hour;
    logic [5:0]        n_minute;

    logic [2:0]        r_sel;
    logic signed [7:0] r_delta;
    logic [15:0]       r_ld_year;
    logic [7:0]        r_ld_month;
    logic [7:0]        r_ld_day;
    logic [7:0]        r_ld_hour;
    logic [7:0]        r_ld_minute;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [11:0]       r_cur_year;
    logic [3:0]        r_cur_month;
    logic [4:0]        r_cur_day;
    logic [4:0]        r_cur_hour;
    logic [5:0]        r_cur_minute;

    logic              w_accept;
    logic              w_finish;
    logic [11:0]       w_ld_year;
    logic [3:0]        w_ld_month;
    logic [4:0]        w_ld_maxd;
    logic [4:0]        w_maxd;
    logic signed [12:0] w_year_sum;
    logic [5:0]        w_field;
    t_wrap_req         w_wreq;
    t_wrap_rsp         w_wrsp;

    ctfe_wrap_unit u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_wreq),
        .o_rsp   (w_wrsp)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_finish = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // load clamps
    assign w_ld_year  = (r_ld_year < 16'(YEAR_MIN)) ? YEAR_MIN :
                        (r_ld_year > 16'(YEAR_MAX)) ? YEAR_MAX : r_ld_year[11:0];
    assign w_ld_month = (r_ld_month == 8'd0) ? 4'd1 :
                        (r_ld_month > 8'd12) ? 4'd12 : r_ld_month[3:0];
    assign w_ld_maxd  = days_in(w_ld_year, w_ld_month);

    assign w_maxd     = days_in(r_year, r_month);
    assign w_year_sum = $signed({1'b0, r_year}) + 13'(r_delta);

    always_comb begin
        case (r_sel)
            FLD_HOUR:   w_field = {1'b0, r_hour};
            FLD_MINUTE: w_field = r_minute;
            FLD_MONTH:  w_field = {2'b00, r_month};
            default:    w_field = {1'b0, r_day};
        endcase
    end

    always_comb begin
        w_wreq.start = (r_state == S_START);
        w_wreq.value = $signed({4'b0000, w_field}) + WRAP_W'(r_delta);
        case (r_sel)
            FLD_HOUR: begin
                w_wreq.lo   = 5'd0;
                w_wreq.span = HOUR_SPAN;
            end
            FLD_MINUTE: begin
                w_wreq.lo   = 5'd0;
                w_wreq.span = MINUTE_SPAN;
            end
            FLD_MONTH: begin
                w_wreq.lo   = 5'd1;
                w_wreq.span = MONTH_SPAN;
            end
            default: begin
                w_wreq.lo   = 5'd1;
                w_wreq.span = {1'b0, w_maxd};
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_delta == 8'sd0 || i_field_sel > FLD_DAY) begin
                        n_state = S_DONE;
                    end else if (i_field_sel == FLD_YEAR) begin
                        n_state = S_YEAR;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_LOAD: begin
                n_year   = w_ld_year;
                n_month  = w_ld_month;
                n_day    = (r_ld_day == 8'd0) ? 5'd1 :
                           (r_ld_day > 8'(w_ld_maxd)) ? w_ld_maxd : r_ld_day[4:0];
                n_hour   = (r_ld_hour > 8'd23) ? 5'd23 : r_ld_hour[4:0];
                n_minute = (r_ld_minute > 8'd59) ? 6'd59 : r_ld_minute[5:0];
                n_state  = S_DONE;
            end
            S_YEAR: begin
                if (w_year_sum < $signed({1'b0, YEAR_MIN})) begin
                    n_year = YEAR_MAX;
                end else if (w_year_sum > $signed({1'b0, YEAR_MAX})) begin
                    n_year = YEAR_MIN;
                end else begin
                    n_year = w_year_sum[11:0];
                end
                n_state = S_CLAMP;
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_wrsp.done) begin
                    case (r_sel)
                        FLD_HOUR:   n_hour   = w_wrsp.result[4:0];
                        FLD_MINUTE: n_minute = w_wrsp.result;
                        FLD_MONTH:  n_month  = w_wrsp.result[3:0];
                        default:    n_day    = w_wrsp.result[4:0];
                    endcase
                    n_state = (r_sel == FLD_MONTH) ? S_CLAMP : S_DONE;
                end
            end
            S_CLAMP: begin
                if (r_day > w_maxd) begin
                    n_day = w_maxd;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_year      <= YEAR_MIN;
            r_month     <= 4'd1;
            r_day       <= 5'd1;
            r_hour      <= 5'd0;
            r_minute    <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_hour      <= n_hour;
            r_minute    <= n_minute;
            r_out_valid <= n_out_valid;
        end
        if (w_accept) begin
            r_sel       <= i_field_sel;
            r_delta     <= i_delta;
            r_ld_year   <= i_load_year;
            r_ld_month  <= i_load_month;
            r_ld_day    <= i_load_day;
            r_ld_hour   <= i_load_hour;
            r_ld_minute <= i_load_minute;
        end
        if (w_finish) begin
            r_cur_year   <= r_year;
            r_cur_month  <= r_month;
            r_cur_day    <= r_day;
            r_cur_hour   <= r_hour;
            r_cur_minute <= r_minute;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cur_year   = r_cur_year;
    assign o_cur_month  = r_cur_month;
    assign o_cur_day    = r_cur_day;
    assign o_cur_hour   = r_cur_hour;
    assign o_cur_minute = r_cur_minute;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted beat did not start work");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> o_valid)
        else $error("finished item not presented");

    a_day_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_day != 5'd0 && r_day <= days_in(r_year, r_month)))
        else $error("day out of month range");

    a_month_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_month >= 4'd1 && r_month <= 4'd12))
        else $error("month out of range");
`endif

endmodule

// File: hdl/ctfe_wrap_unit.sv
// ----------------------------------------------------------------------------
// ctfe_wrap_unit
// iterative wrap of a signed value into lo..lo+span-1, one add or
// subtract of the span per cycle
// ----------------------------------------------------------------------------
module ctfe_wrap_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ctfe_pkg::t_wrap_req  i_req,
    output ctfe_pkg::t_wrap_rsp  o_rsp
);
    import ctfe_pkg::*;

    logic                     r_busy;
    logic                     n_busy;
    logic signed [WRAP_W-1:0] r_val;
    logic signed [WRAP_W-1:0] n_val;
    logic signed [WRAP_W-1:0] r_lo;
    logic signed [WRAP_W-1:0] r_hi;
    logic signed [WRAP_W-1:0] r_span;
    logic                     w_below;
    logic                     w_above;

    assign w_below = r_val < r_lo;
    assign w_above = r_val > r_hi;

    always_comb begin
        n_busy = r_busy;
        n_val  = r_val;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_val  = i_req.value;
        end else if (r_busy) begin
            if (w_below) begin
                n_val = r_val + r_span;
            end else if (w_above) begin
                n_val = r_val - r_span;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_val <= n_val;
        if (i_req.start) begin
            r_lo   <= WRAP_W'(i_req.lo);
            r_hi   <= WRAP_W'(i_req.lo) + WRAP_W'(i_req.span) - WRAP_W'(1);
            r_span <= WRAP_W'(i_req.span);
        end
    end

    assign o_rsp.done   = r_busy && !w_below && !w_above && !i_req.start;
    assign o_rsp.result = r_val[5:0];

endmodule
